// ----- rtl/pmf_pkg.sv -----
// Package for the per-symbol price move flagger.
// Holds the request and result types, the configuration set and register codes.
`timescale 1ns / 1ps
`default_nettype none
package pmf_pkg;

	localparam int NUM_SLOTS = 3;
	localparam int THR_W = 24;
	localparam int SYM_W = 64;
	localparam int PRICE_W = 48;
	localparam int ADDR_W = 6;
	localparam int DATA_W = 64;
	localparam logic [THR_W-1:0] THR_RESET = 24'd100000;

	localparam logic [2:0] REG_DEFAULT_THR = 3'd0;
	localparam logic [2:0] REG_OVR_SYM_A = 3'd1;
	localparam logic [2:0] REG_OVR_THR_A = 3'd2;
	localparam logic [2:0] REG_OVR_SYM_B = 3'd3;
	localparam logic [2:0] REG_OVR_THR_B = 3'd4;
	localparam logic [2:0] REG_OVR_SYM_C = 3'd5;
	localparam logic [2:0] REG_OVR_THR_C = 3'd6;

	typedef struct packed {
		logic [SYM_W-1:0] symbol;
		logic signed [PRICE_W-1:0] price;
	} in_t;

	typedef struct packed {
		logic critical;
		logic untracked;
	} out_t;

	typedef struct packed {
		logic valid;
		logic done;
		logic found;
		logic signed [PRICE_W-1:0] last;
	} token_t;

	typedef struct packed {
		logic [THR_W-1:0] default_thr;
		logic [NUM_SLOTS-1:0][SYM_W-1:0] ovr_sym;
		logic [NUM_SLOTS-1:0][THR_W-1:0] ovr_thr;
	} cfg_t;

endpackage
`default_nettype wire

// ----- rtl/pmf_cfg.sv -----
// Configuration register file with the APB-style write and read port.
// Depends on pmf_pkg for the register codes and the cfg_t bundle.
`timescale 1ns / 1ps
`default_nettype none
module pmf_cfg (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [pmf_pkg::ADDR_W-1:0]    paddr,
	input  wire logic [pmf_pkg::DATA_W-1:0]    pwdata,
	output logic      [pmf_pkg::DATA_W-1:0]    prdata,
	output pmf_pkg::cfg_t                      cfg
);

	pmf_pkg::cfg_t cfg_q;
	logic [2:0] idx;
	logic wr_en;

	assign idx = paddr[pmf_pkg::ADDR_W-1:3];
	assign wr_en = psel && penable && pwrite;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.default_thr <= pmf_pkg::THR_RESET;
			for (int k = 0; k < pmf_pkg::NUM_SLOTS; k++) begin
				cfg_q.ovr_sym[k] <= '0;
				cfg_q.ovr_thr[k] <= pmf_pkg::THR_RESET;
			end
		end else if (wr_en) begin
			case (idx)
				pmf_pkg::REG_DEFAULT_THR: cfg_q.default_thr <= pwdata[pmf_pkg::THR_W-1:0];
				pmf_pkg::REG_OVR_SYM_A: cfg_q.ovr_sym[0] <= pwdata;
				pmf_pkg::REG_OVR_THR_A: cfg_q.ovr_thr[0] <= pwdata[pmf_pkg::THR_W-1:0];
				pmf_pkg::REG_OVR_SYM_B: cfg_q.ovr_sym[1] <= pwdata;
				pmf_pkg::REG_OVR_THR_B: cfg_q.ovr_thr[1] <= pwdata[pmf_pkg::THR_W-1:0];
				pmf_pkg::REG_OVR_SYM_C: cfg_q.ovr_sym[2] <= pwdata;
				pmf_pkg::REG_OVR_THR_C: cfg_q.ovr_thr[2] <= pwdata[pmf_pkg::THR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			pmf_pkg::REG_DEFAULT_THR: prdata = {40'd0, cfg_q.default_thr};
			pmf_pkg::REG_OVR_SYM_A: prdata = cfg_q.ovr_sym[0];
			pmf_pkg::REG_OVR_THR_A: prdata = {40'd0, cfg_q.ovr_thr[0]};
			pmf_pkg::REG_OVR_SYM_B: prdata = cfg_q.ovr_sym[1];
			pmf_pkg::REG_OVR_THR_B: prdata = {40'd0, cfg_q.ovr_thr[1]};
			pmf_pkg::REG_OVR_SYM_C: prdata = cfg_q.ovr_sym[2];
			pmf_pkg::REG_OVR_THR_C: prdata = {40'd0, cfg_q.ovr_thr[2]};
			default: prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

// ----- rtl/pmf_cell.sv -----
// One table cell: holds a symbol and its last price, passes the search token on.
// Depends on pmf_pkg for token_t and the field widths.
`timescale 1ns / 1ps
`default_nettype none
module pmf_cell (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire pmf_pkg::token_t                     tok_in,
	input  wire logic [pmf_pkg::SYM_W-1:0]           sym,
	input  wire logic signed [pmf_pkg::PRICE_W-1:0]  price,
	output pmf_pkg::token_t                          tok_out
);

	logic valid_q;
	logic [pmf_pkg::SYM_W-1:0] sym_q;
	logic signed [pmf_pkg::PRICE_W-1:0] price_q;
	pmf_pkg::token_t tok_q;
	pmf_pkg::token_t tok_nx;
	logic hit;
	logic act;

	assign hit = valid_q && (sym_q == sym);
	assign act = tok_in.valid && !tok_in.done && (hit || !valid_q);
	assign tok_out = tok_q;

	always_comb begin
		tok_nx = tok_in;
		if (act) begin
			tok_nx.done = 1'b1;
			tok_nx.found = hit;
			tok_nx.last = price_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			tok_q <= '0;
		end else begin
			tok_q <= tok_nx;
			if (act) begin
				valid_q <= 1'b1;
			end
		end
	end

	// claim an empty cell or refresh the matched price
	always_ff @(posedge clk) begin
		if (act) begin
			price_q <= price;
			if (!valid_q) begin
				sym_q <= sym;
			end
		end
	end

endmodule
`default_nettype wire

// ----- rtl/pmf_band.sv -----
// Band check after the cell row: |new-last|*10000 against threshold*|last|.
// Depends on pmf_pkg for token_t and out_t.
`timescale 1ns / 1ps
`default_nettype none
module pmf_band (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire pmf_pkg::token_t                     tok,
	input  wire logic signed [pmf_pkg::PRICE_W-1:0]  price,
	input  wire logic [pmf_pkg::THR_W-1:0]           thr,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output pmf_pkg::out_t                            out_data
);

	logic signed [pmf_pkg::PRICE_W:0] diff;
	logic [pmf_pkg::PRICE_W:0] diff_mag;
	logic [pmf_pkg::PRICE_W-1:0] last_mag;

	logic valid_s1;
	logic need_s1;
	logic untracked_s1;
	logic [47:0] ad_s1;
	logic [47:0] al_s1;

	logic valid_s2;
	logic need_s2;
	logic untracked_s2;
	logic [61:0] lhs_s2;
	logic [47:0] plo_s2;
	logic [47:0] phi_s2;

	logic [71:0] rhs;
	logic out_valid_q;
	pmf_pkg::out_t out_q;

	assign diff = {price[47], price} - {tok.last[47], tok.last};
	assign diff_mag = diff[48] ? (~diff + 49'd1) : diff;
	assign last_mag = tok.last[47] ? (~tok.last + 48'd1) : tok.last;
	assign rhs = {phi_s2, 24'd0} + {24'd0, plo_s2};
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			valid_s1 <= tok.valid;
			valid_s2 <= valid_s1;
			if (valid_s2) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		need_s1 <= tok.found && (tok.last != '0);
		untracked_s1 <= !tok.done;
		ad_s1 <= diff_mag[47:0];
		al_s1 <= last_mag;

		need_s2 <= need_s1;
		untracked_s2 <= untracked_s1;
		lhs_s2 <= {14'd0, ad_s1} * 62'd10000;
		plo_s2 <= {24'd0, thr} * {24'd0, al_s1[23:0]};
		phi_s2 <= {24'd0, thr} * {24'd0, al_s1[47:24]};

		if (valid_s2) begin
			out_q.critical <= need_s2 && ({10'd0, lhs_s2} > rhs);
			out_q.untracked <= untracked_s2;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/per_symbol_price_move_flagger.sv -----
// Per-symbol price move flagger, top level.
// An accepted request is registered into start_q, walks the cell row, then passes
// the band stages s1 and s2 and the output register. The search token walks the
// whole cell row, one cell per cycle; one request is in flight until its result is taken.
// Reset clears every cell's valid bit at once and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none
module per_symbol_price_move_flagger #(
	parameter int TABLE_DEPTH = 64,
	parameter int SYMBOL_BYTES = 8,
	parameter int OVERRIDE_SLOTS = 3
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire pmf_pkg::in_t                  in_data,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output pmf_pkg::out_t                      out_data,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [pmf_pkg::ADDR_W-1:0]    paddr,
	input  wire logic [pmf_pkg::DATA_W-1:0]    pwdata,
	output logic      [pmf_pkg::DATA_W-1:0]    prdata,
	output logic                               pready
);

	localparam logic [pmf_pkg::SYM_W-1:0] SYM_MASK = (SYMBOL_BYTES >= 8) ? '1 :
		((64'd1 << (8 * SYMBOL_BYTES)) - 64'd1);

	pmf_pkg::cfg_t cfg;
	pmf_pkg::token_t tok [TABLE_DEPTH+1];

	logic busy_q;
	logic start_q;
	logic [pmf_pkg::SYM_W-1:0] sym_q;
	logic signed [pmf_pkg::PRICE_W-1:0] price_q;
	logic [pmf_pkg::THR_W-1:0] thr_q;
	logic [pmf_pkg::SYM_W-1:0] sym_m;
	logic [pmf_pkg::THR_W-1:0] thr_pick;
	logic in_acc;
	logic out_acc;

	assign pready = 1'b1;
	assign in_stall = busy_q;
	assign in_acc = in_valid && !busy_q;
	assign out_acc = out_valid && !out_stall;
	assign sym_m = in_data.symbol & SYM_MASK;

	// earliest matching override slot wins
	always_comb begin
		thr_pick = cfg.default_thr;
		for (int k = pmf_pkg::NUM_SLOTS - 1; k >= 0; k--) begin
			if (k < OVERRIDE_SLOTS && (cfg.ovr_sym[k] & SYM_MASK) != '0 &&
					(cfg.ovr_sym[k] & SYM_MASK) == sym_m) begin
				thr_pick = cfg.ovr_thr[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			start_q <= 1'b0;
		end else begin
			start_q <= in_acc;
			if (in_acc) begin
				busy_q <= 1'b1;
			end else if (out_acc) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			sym_q <= sym_m;
			price_q <= in_data.price;
			thr_q <= thr_pick;
		end
	end

	pmf_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	assign tok[0] = '{valid: start_q, done: 1'b0, found: 1'b0, last: '0};

	for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
		pmf_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.tok_in  (tok[g]),
			.sym     (sym_q),
			.price   (price_q),
			.tok_out (tok[g+1])
		);
	end

	pmf_band u_band (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok       (tok[TABLE_DEPTH]),
		.price     (price_q),
		.thr       (thr_q),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	a_out_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> busy_q)
		else $error("result shown with no request in flight");

	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.critical && out_data.untracked))
		else $error("untracked result also flagged critical");

	a_chain_end: assert property (@(posedge clk) disable iff (!arst_n)
		tok[TABLE_DEPTH].valid |-> (busy_q && !out_valid))
		else $error("search token left the row while a result waits");

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start_q |-> !out_valid)
		else $error("new search started while a result waits");

endmodule
`default_nettype wire
